// ===== src/lcasr_pkg.sv =====
// Shared constants and types for the load cell converter serial reader.
package lcasr_pkg;

    localparam int EXTRA_W    = 2;
    localparam int TICK_W     = 16;
    localparam int AVG_W      = 8;
    localparam int OFF_W      = 24;
    localparam int RES_W      = 25;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_PULSES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PD_HOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 3'd4;

    localparam logic [EXTRA_W-1:0] RST_EXTRA_PULSES  = 2'd1;
    localparam logic [TICK_W-1:0]  RST_READY_TIMEOUT = 16'd5000;
    localparam logic [TICK_W-1:0]  RST_PD_HOLD       = 16'd300;
    localparam logic [AVG_W-1:0]   RST_AVERAGE_COUNT = 8'd1;
    localparam logic [OFF_W-1:0]   RST_ZERO_OFFSET   = 24'd0;

    localparam int RES_MAX = 16777215;
    localparam int RES_MIN = -16777216;

    typedef logic [AVG_W-1:0] t_count;

endpackage

// ===== src/load_cell_adc_serial_reader.sv =====
// Top level of the load cell converter serial reader.
//
// Every input beat on the s_axis channel is one timebase tick carrying the
// start request and the sampled converter data pin. Every accepted tick gives
// exactly one output beat on the m_axis channel: the clock pin level for that
// tick, the busy flag, and on the finishing tick of a measurement the result.
// An ordinary tick's beat appears in the output register on the cycle after the
// tick is accepted, so ticks can stream at one per cycle while the receiver
// keeps taking beats. The finishing tick of an averaged measurement runs a
// bit-serial divider of SAMPLE_BITS+8 steps, then registers the sign-corrected
// quotient, then subtracts the offset, saturates and loads the output beat;
// no tick is taken meanwhile.
// When the receiver stalls, the pending beat holds in the output register and
// the next tick is not taken until that beat leaves.
// Reset returns the sequencer to idle with the converter clock high and loads
// the registers with their default values. Registers are written through the
// cfg port, one per cycle, and should only be written while no tick is pending.
module load_cell_adc_serial_reader #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] start_request, [1] dout_level, [7:2] zero
    input  logic [lcasr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] pd_sck_level, [1] busy_res, [26:2] result_value, [31:27] zero
    output logic [lcasr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] result_valid, [1] timed_out
    output logic [lcasr_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [lcasr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lcasr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DW     = SAMPLE_BITS + 8;
    localparam int DIFF_W = DW + 1;
    localparam int BC_W   = $clog2(SAMPLE_BITS + 1);
    localparam int TW     = lcasr_pkg::TICK_W;
    localparam int RW     = lcasr_pkg::RES_W;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT       = 3'd1;
    localparam logic [2:0] PH_CLK_HIGH   = 3'd2;
    localparam logic [2:0] PH_CLK_LOW    = 3'd3;
    localparam logic [2:0] PH_PULSE_HIGH = 3'd4;
    localparam logic [2:0] PH_PULSE_LOW  = 3'd5;
    localparam logic [2:0] PH_HOLD       = 3'd6;

    localparam logic [1:0] C_RUN = 2'd0;
    localparam logic [1:0] C_DIV = 2'd1;
    localparam logic [1:0] C_SAT = 2'd2;

    localparam logic signed [DIFF_W-1:0] L_MAX = DIFF_W'(lcasr_pkg::RES_MAX);
    localparam logic signed [DIFF_W-1:0] L_MIN = DIFF_W'(lcasr_pkg::RES_MIN);

    logic [lcasr_pkg::EXTRA_W-1:0]  r_extra;
    logic [TW-1:0]                  r_timeout;
    logic [TW-1:0]                  r_hold;
    lcasr_pkg::t_count              r_avg;
    logic [lcasr_pkg::OFF_W-1:0]    r_off;

    logic [2:0]               r_phase, n_phase;
    logic [TW-1:0]            r_tick, n_tick;
    logic [BC_W-1:0]          r_bits, n_bits;
    logic [1:0]               r_pulse, n_pulse;
    logic [SAMPLE_BITS-1:0]   r_shift, n_shift;
    logic signed [DW-1:0]     r_sum, n_sum;
    lcasr_pkg::t_count        r_reads, n_reads;
    logic [1:0]               r_ctl;

    logic                     r_neg;
    logic signed [DW-1:0]     r_val;

    logic                     r_out_valid;
    logic                     r_out_sck;
    logic                     r_out_busy;
    logic                     r_out_rv;
    logic                     r_out_tmo;
    logic [RW-1:0]            r_out_value;

    logic                     w_start;
    logic                     w_dout;
    logic                     w_acc;
    logic                     w_out_free;
    logic                     w_sck, w_busy, w_rv, w_tmo, w_fin;
    logic [1:0]               w_pulses;
    lcasr_pkg::t_count        w_count;
    logic [TW:0]              w_tick_inc;
    logic [DW-1:0]            w_mag;
    logic                     w_div_done;
    logic [DW-1:0]            w_quo;
    logic signed [DIFF_W-1:0] w_diff;
    logic [RW-1:0]            w_sat;

    assign w_start    = s_axis_tdata[0];
    assign w_dout     = s_axis_tdata[1];
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_ctl == C_RUN) && w_out_free;
    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_pulses   = (r_extra == '0) ? 2'd1 : r_extra;
    assign w_count    = (r_avg == '0) ? lcasr_pkg::AVG_W'(1) : r_avg;
    assign w_tick_inc = {1'b0, r_tick} + 1'b1;
    assign w_mag      = r_sum[DW-1] ? DW'(-r_sum) : DW'(r_sum);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bits  = r_bits;
        n_pulse = r_pulse;
        n_shift = r_shift;
        n_sum   = r_sum;
        n_reads = r_reads;
        w_sck   = 1'b1;
        w_busy  = 1'b1;
        w_rv    = 1'b0;
        w_tmo   = 1'b0;
        w_fin   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_start) begin
                    n_phase = PH_WAIT;
                    n_tick  = '0;
                    n_reads = '0;
                    n_sum   = '0;
                    w_sck   = 1'b0;
                end else begin
                    w_busy = 1'b0;
                end
            end
            PH_WAIT: begin
                w_sck = 1'b0;
                if (!w_dout) begin
                    n_phase = PH_CLK_HIGH;
                    n_bits  = '0;
                    n_shift = '0;
                end else if (r_tick >= r_timeout) begin
                    n_phase = PH_IDLE;
                    n_sum   = '0;
                    w_sck   = 1'b1;
                    w_busy  = 1'b0;
                    w_rv    = 1'b1;
                    w_tmo   = 1'b1;
                end else begin
                    n_tick = w_tick_inc[TW-1:0];
                end
            end
            PH_CLK_HIGH: begin
                n_shift = {r_shift[SAMPLE_BITS-2:0], w_dout};
                n_bits  = r_bits + 1'b1;
                n_phase = PH_CLK_LOW;
            end
            PH_CLK_LOW: begin
                w_sck = 1'b0;
                if (r_bits >= BC_W'(SAMPLE_BITS)) begin
                    n_phase = PH_PULSE_HIGH;
                    n_pulse = '0;
                end else begin
                    n_phase = PH_CLK_HIGH;
                end
            end
            PH_PULSE_HIGH: begin
                n_pulse = r_pulse + 1'b1;
                n_phase = PH_PULSE_LOW;
            end
            PH_PULSE_LOW: begin
                w_sck = 1'b0;
                if (r_pulse >= w_pulses) begin
                    n_sum   = r_sum + DW'($signed(r_shift));
                    n_reads = r_reads + 1'b1;
                    n_tick  = '0;
                    n_phase = PH_HOLD;
                end else begin
                    n_phase = PH_PULSE_HIGH;
                end
            end
            PH_HOLD: begin
                n_tick = w_tick_inc[TW-1:0];
                if (w_tick_inc >= {1'b0, r_hold}) begin
                    if (r_reads >= w_count) begin
                        n_phase = PH_IDLE;
                        w_fin   = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                w_busy  = 1'b0;
            end
        endcase
    end

    lcasr_div #(
        .WIDTH(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && w_fin),
        .i_dividend (w_mag),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_diff = DIFF_W'(r_val) - DIFF_W'($signed(r_off));

    always_comb begin
        if (w_diff > L_MAX) begin
            w_sat = RW'(L_MAX);
        end else if (w_diff < L_MIN) begin
            w_sat = RW'(L_MIN);
        end else begin
            w_sat = w_diff[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra     <= lcasr_pkg::RST_EXTRA_PULSES;
            r_timeout   <= lcasr_pkg::RST_READY_TIMEOUT;
            r_hold      <= lcasr_pkg::RST_PD_HOLD;
            r_avg       <= lcasr_pkg::RST_AVERAGE_COUNT;
            r_off       <= lcasr_pkg::RST_ZERO_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcasr_pkg::REG_EXTRA_PULSES:  r_extra   <= i_cfg_data[lcasr_pkg::EXTRA_W-1:0];
                lcasr_pkg::REG_READY_TIMEOUT: r_timeout <= i_cfg_data[TW-1:0];
                lcasr_pkg::REG_PD_HOLD:       r_hold    <= i_cfg_data[TW-1:0];
                lcasr_pkg::REG_AVERAGE_COUNT: r_avg     <= i_cfg_data[lcasr_pkg::AVG_W-1:0];
                lcasr_pkg::REG_ZERO_OFFSET:   r_off     <= i_cfg_data[lcasr_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bits      <= '0;
            r_pulse     <= '0;
            r_shift     <= '0;
            r_sum       <= '0;
            r_reads     <= '0;
            r_ctl       <= C_RUN;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bits  <= n_bits;
                r_pulse <= n_pulse;
                r_shift <= n_shift;
                r_sum   <= n_sum;
                r_reads <= n_reads;
            end
            priority case (r_ctl)
                C_RUN: begin
                    if (w_acc && w_fin) begin
                        r_ctl <= C_DIV;
                    end
                end
                C_DIV: begin
                    if (w_div_done) begin
                        r_ctl <= C_SAT;
                    end
                end
                C_SAT: begin
                    if (w_out_free) begin
                        r_ctl <= C_RUN;
                    end
                end
                default: r_ctl <= C_RUN;
            endcase
            if (w_acc && !w_fin) begin
                r_out_valid <= 1'b1;
            end else if (r_ctl == C_SAT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_fin) begin
            r_neg <= r_sum[DW-1];
        end
        if (w_div_done) begin
            r_val <= r_neg ? -$signed(w_quo) : $signed(w_quo);
        end
        if (w_acc && !w_fin) begin
            r_out_sck   <= w_sck;
            r_out_busy  <= w_busy;
            r_out_rv    <= w_rv;
            r_out_tmo   <= w_tmo;
            r_out_value <= '0;
        end else if (r_ctl == C_SAT && w_out_free) begin
            r_out_sck   <= 1'b1;
            r_out_busy  <= 1'b0;
            r_out_rv    <= 1'b1;
            r_out_tmo   <= 1'b0;
            r_out_value <= w_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(lcasr_pkg::OUT_TDATA_W - RW - 2){1'b0}},
                            r_out_value, r_out_busy, r_out_sck};
    assign m_axis_tuser  = {r_out_tmo, r_out_rv};

    a_div_only_when_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_ctl == C_DIV)
        else $error("divider finished outside of the divide step");

    a_idle_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == C_DIV || r_ctl == C_SAT) |-> r_phase == PH_IDLE)
        else $error("sequencer left idle while a result was being formed");

    a_high_then_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_CLK_HIGH) |=> r_phase == PH_CLK_LOW && r_out_sck)
        else $error("data bit high half not followed by its low half");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BC_W'(SAMPLE_BITS))
        else $error("bit count ran past the sample width");

    a_timeout_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tmo) |-> (r_out_rv && !r_out_busy && r_out_value == '0))
        else $error("timeout beat without a clean zero result");

endmodule

// ===== src/lcasr_div.sv =====
// Bit-serial restoring divider of an unsigned magnitude by an 8-bit count.
module lcasr_div #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH-1:0]      i_dividend,
    input  lcasr_pkg::t_count     i_divisor,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_quotient
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int RW = lcasr_pkg::AVG_W;

    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [WIDTH-1:0]  r_quo;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_dsr;

    logic [RW:0]       w_sh;
    logic [RW:0]       w_sub;
    logic              w_ge;

    assign w_sh  = {r_rem, r_quo[WIDTH-1]};
    assign w_ge  = w_sh >= {1'b0, r_dsr};
    assign w_sub = w_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
            r_rem <= w_ge ? w_sub[RW-1:0] : w_sh[RW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== bench/tb.sv =====
// Testbench for the load cell converter serial reader: tick-by-tick prediction of all output beats.
`timescale 1ns / 1ps

module tb;

    localparam int NBITS = 24;
    localparam int CFG_W = lcasr_pkg::CFG_DATA_W;
    localparam int RES_W = lcasr_pkg::RES_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_BIT_HI  = 3'd2;
    localparam logic [2:0] ST_BIT_LO  = 3'd3;
    localparam logic [2:0] ST_GAIN_HI = 3'd4;
    localparam logic [2:0] ST_GAIN_LO = 3'd5;
    localparam logic [2:0] ST_HOLD    = 3'd6;

    typedef struct packed {
        logic             sck;
        logic             busy;
        logic             valid;
        logic             tmo;
        logic [RES_W-1:0] value;
    } t_tick_out;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    // [0] start_request, [1] dout_level, [7:2] zero
    logic [lcasr_pkg::IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    // [0] pd_sck_level, [1] busy_res, [26:2] result_value, [31:27] zero
    logic [lcasr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    // [0] result_valid, [1] timed_out
    logic [lcasr_pkg::OUT_TUSER_W-1:0]     m_axis_tuser;
    logic                                  i_cfg_we = 1'b0;
    logic [lcasr_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]                      i_cfg_data = '0;

    load_cell_adc_serial_reader #(
        .SAMPLE_BITS(NBITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    logic [lcasr_pkg::EXTRA_W-1:0]      cfg_extra = lcasr_pkg::RST_EXTRA_PULSES;
    logic [lcasr_pkg::TICK_W-1:0]       cfg_timeout = lcasr_pkg::RST_READY_TIMEOUT;
    logic [lcasr_pkg::TICK_W-1:0]       cfg_hold = lcasr_pkg::RST_PD_HOLD;
    logic [lcasr_pkg::AVG_W-1:0]        cfg_avg = lcasr_pkg::RST_AVERAGE_COUNT;
    logic signed [lcasr_pkg::OFF_W-1:0] cfg_offset = lcasr_pkg::RST_ZERO_OFFSET;

    logic [2:0]       rd_state = ST_IDLE;
    int unsigned      tick_cnt = 0;
    int unsigned      bit_cnt = 0;
    int unsigned      pulse_cnt = 0;
    logic [NBITS-1:0] shift_w = '0;
    longint           run_sum = 0;
    int unsigned      reads_done = 0;

    t_tick_out tick_out_q[$];

    logic [NBITS-1:0] forced_words[$];
    int               forced_dly[$];
    logic [NBITS-1:0] cur_word = '0;
    int               ready_dly = 0;
    logic             dly_armed = 1'b0;
    logic             src_offering = 1'b0;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_hold = 0;
    int hang_pct = 0;
    int noise_pct = 0;

    int fail_count = 0;
    int n_ticks = 0;
    int n_results = 0;
    int n_timeouts = 0;
    int n_writes = 0;
    int rand_ticks = 0;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [NBITS-1:0] next_word();
        int r;
        if (forced_words.size() != 0) return forced_words.pop_front();
        r = $urandom_range(0, 9);
        case (r)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
            default: return NBITS'($urandom);
        endcase
    endfunction

    function automatic int pick_ready();
        int r;
        if (forced_dly.size() != 0) return forced_dly.pop_front();
        r = $urandom_range(0, 99);
        if (r < hang_pct) return int'(cfg_timeout) + 1;
        if (r < 70) return $urandom_range(0, 2);
        return $urandom_range(3, 15);
    endfunction

    // Converter side: holds the data pin high for a while, then presents a word MSB first.
    function automatic logic conv_dout();
        logic d;
        d = 1'($urandom_range(0, 1));
        if (rd_state != ST_WAIT) dly_armed = 1'b0;
        if (rd_state == ST_WAIT) begin
            if (!dly_armed) begin
                ready_dly = pick_ready();
                dly_armed = 1'b1;
            end
            if (ready_dly == 0) begin
                d = 1'b0;
                dly_armed = 1'b0;
                cur_word = next_word();
            end else begin
                d = 1'b1;
                ready_dly--;
            end
        end else if (rd_state == ST_BIT_HI) begin
            d = cur_word[NBITS-1-bit_cnt];
        end
        return d;
    endfunction

    task automatic step_reader(input logic st, input logic d);
        t_tick_out               o;
        int unsigned             pulses;
        int unsigned             count;
        longint                  val;
        logic signed [NBITS-1:0] samp;
        o = '0;
        o.sck = 1'b1;
        o.busy = 1'b1;
        pulses = (cfg_extra == 0) ? 1 : cfg_extra;
        count = (cfg_avg == 0) ? 1 : cfg_avg;
        case (rd_state)
            ST_IDLE: begin
                if (st) begin
                    rd_state = ST_WAIT;
                    tick_cnt = 0;
                    reads_done = 0;
                    run_sum = 0;
                    o.sck = 1'b0;
                end else begin
                    o.busy = 1'b0;
                end
            end
            ST_WAIT: begin
                o.sck = 1'b0;
                if (!d) begin
                    rd_state = ST_BIT_HI;
                    bit_cnt = 0;
                    shift_w = '0;
                end else if (tick_cnt >= cfg_timeout) begin
                    rd_state = ST_IDLE;
                    run_sum = 0;
                    o.sck = 1'b1;
                    o.busy = 1'b0;
                    o.valid = 1'b1;
                    o.tmo = 1'b1;
                    n_timeouts++;
                end else begin
                    tick_cnt = (tick_cnt + 1) & 32'hFFFF;
                end
            end
            ST_BIT_HI: begin
                shift_w = {shift_w[NBITS-2:0], d};
                bit_cnt = (bit_cnt + 1) & 32'h3F;
                rd_state = ST_BIT_LO;
            end
            ST_BIT_LO: begin
                o.sck = 1'b0;
                if (bit_cnt >= NBITS) begin
                    rd_state = ST_GAIN_HI;
                    pulse_cnt = 0;
                end else begin
                    rd_state = ST_BIT_HI;
                end
            end
            ST_GAIN_HI: begin
                pulse_cnt = (pulse_cnt + 1) & 32'h3;
                rd_state = ST_GAIN_LO;
            end
            ST_GAIN_LO: begin
                o.sck = 1'b0;
                if (pulse_cnt >= pulses) begin
                    samp = shift_w;
                    run_sum += samp;
                    reads_done = (reads_done + 1) & 32'hFF;
                    tick_cnt = 0;
                    rd_state = ST_HOLD;
                end else begin
                    rd_state = ST_GAIN_HI;
                end
            end
            ST_HOLD: begin
                tick_cnt = (tick_cnt + 1) & 32'h1FFFF;
                if (tick_cnt >= cfg_hold) begin
                    if (reads_done >= count) begin
                        val = run_sum / longint'(count) - longint'(cfg_offset);
                        if (val > lcasr_pkg::RES_MAX) val = lcasr_pkg::RES_MAX;
                        if (val < lcasr_pkg::RES_MIN) val = lcasr_pkg::RES_MIN;
                        rd_state = ST_IDLE;
                        o.busy = 1'b0;
                        o.valid = 1'b1;
                        o.value = val[RES_W-1:0];
                        n_results++;
                    end else begin
                        rd_state = ST_WAIT;
                        tick_cnt = 0;
                    end
                end
            end
            default: begin
                rd_state = ST_IDLE;
                o.busy = 1'b0;
            end
        endcase
        tick_out_q.push_back(o);
        n_ticks++;
    endtask

    task automatic send_tick(input logic st, input logic d);
        s_axis_tdata <= {{(lcasr_pkg::IN_TDATA_W-2){1'b0}}, d, st};
        s_axis_tvalid <= 1'b1;
        src_offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        step_reader(st, d);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            src_offering = 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // While busy the start request is random, so starts during a measurement get exercised.
    task automatic next_tick(input int start_pct);
        logic st;
        logic d;
        if (rd_state == ST_IDLE) st = ($urandom_range(0, 99) < start_pct);
        else st = 1'($urandom_range(0, 1));
        d = conv_dout();
        if ($urandom_range(0, 99) < noise_pct) d = 1'($urandom_range(0, 1));
        send_tick(st, d);
    endtask

    task automatic drain();
        if (src_offering) begin
            s_axis_tvalid <= 1'b0;
            src_offering = 1'b0;
        end
        while (tick_out_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lcasr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lcasr_pkg::REG_EXTRA_PULSES:  cfg_extra = val[lcasr_pkg::EXTRA_W-1:0];
            lcasr_pkg::REG_READY_TIMEOUT: cfg_timeout = val[lcasr_pkg::TICK_W-1:0];
            lcasr_pkg::REG_PD_HOLD:       cfg_hold = val[lcasr_pkg::TICK_W-1:0];
            lcasr_pkg::REG_AVERAGE_COUNT: cfg_avg = val[lcasr_pkg::AVG_W-1:0];
            lcasr_pkg::REG_ZERO_OFFSET:   cfg_offset = val[lcasr_pkg::OFF_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic set_config(input int extra, input int tmo_ticks, input int hold,
                              input int avg, input int offset);
        drain();
        write_reg(lcasr_pkg::REG_EXTRA_PULSES, CFG_W'(extra));
        write_reg(lcasr_pkg::REG_READY_TIMEOUT, CFG_W'(tmo_ticks));
        write_reg(lcasr_pkg::REG_PD_HOLD, CFG_W'(hold));
        write_reg(lcasr_pkg::REG_AVERAGE_COUNT, CFG_W'(avg));
        write_reg(lcasr_pkg::REG_ZERO_OFFSET, CFG_W'(offset));
    endtask

    task automatic measure();
        send_tick(1'b1, conv_dout());
        while (rd_state != ST_IDLE) next_tick(0);
        forced_words.delete();
        forced_dly.delete();
    endtask

    task automatic test_idle_after_reset();
        src_idle_pct = 20;
        sink_idle_pct = 20;
        repeat (6) next_tick(0);
    endtask

    task automatic test_default_read();
        forced_words.push_back(24'h123456);
        measure();
    endtask

    task automatic test_gain_pulses();
        for (int e = 0; e < 4; e++) begin
            set_config(e, 20, 2, 1, 0);
            measure();
        end
    endtask

    task automatic test_result_range();
        set_config(1, 20, 0, 1, -8388608);
        forced_words.push_back(24'h7FFFFF);
        measure();
        set_config(3, 20, 0, 1, 8388607);
        forced_words.push_back(24'h800000);
        measure();
        set_config(2, 20, 0, 1, 0);
        forced_words.push_back(24'hFFFFFF);
        measure();
    endtask

    task automatic test_ready_timeout();
        set_config(1, 0, 2, 1, 0);
        forced_dly.push_back(1);
        measure();
        forced_dly.push_back(0);
        measure();
        set_config(1, 3, 2, 1, 0);
        forced_dly.push_back(3);
        measure();
        forced_dly.push_back(4);
        measure();
        // The first read succeeds, the second times out and the partial sum is dropped.
        set_config(1, 3, 2, 2, 0);
        forced_dly.push_back(0);
        forced_dly.push_back(4);
        measure();
    endtask

    task automatic test_short_hold();
        set_config(2, 20, 0, 2, 5);
        measure();
        set_config(2, 20, 1, 2, -5);
        measure();
    endtask

    task automatic test_averaging();
        set_config(1, 20, 1, 0, 0);
        forced_words.push_back(24'h400000);
        measure();
        set_config(1, 20, 0, 3, 0);
        forced_words.push_back(24'hFFFFFF);
        forced_words.push_back(24'hFFFFFF);
        forced_words.push_back(24'h000001);
        measure();
        forced_words.push_back(24'hFFFFFB);
        forced_words.push_back(24'h000000);
        forced_words.push_back(24'h000000);
        measure();
    endtask

    task automatic test_config_mid_run();
        set_config(1, 20, 3, 2, 0);
        send_tick(1'b1, conv_dout());
        while (!(rd_state == ST_HOLD && reads_done == 1)) next_tick(0);
        drain();
        write_reg(lcasr_pkg::REG_AVERAGE_COUNT, CFG_W'(3));
        write_reg(lcasr_pkg::REG_ZERO_OFFSET, CFG_W'(-100));
        write_reg(lcasr_pkg::REG_EXTRA_PULSES, CFG_W'(3));
        while (rd_state != ST_IDLE) next_tick(0);
    endtask

    task automatic test_backpressure();
        set_config(1, 10, 2, 2, 16);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold = 250;
        repeat (120) next_tick(100);
        drain();
        src_idle_pct = 20;
        sink_idle_pct = 20;
        repeat (60) next_tick(100);
        drain();
    endtask

    task automatic test_limits();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        // The longest timeout with a long but finite wait for the data pin.
        set_config(3, 65535, 2, 1, 0);
        forced_dly.push_back(40);
        forced_words.push_back(24'h5A5A5A);
        measure();
        set_config(2, 20, 0, 2, 8388607);
        repeat (2) forced_words.push_back(24'h800000);
        measure();
        set_config(1, 20, 0, 3, -8388608);
        repeat (3) forced_words.push_back(24'h7FFFFF);
        measure();
    endtask

    task automatic test_random_traffic();
        int r;
        int tmo_ticks;
        int hold;
        int avg;
        int start_pct;
        while (rand_ticks < 400) begin
            r = $urandom_range(0, 9);
            tmo_ticks = (r == 0) ? 0 : $urandom_range(1, 40);
            r = $urandom_range(0, 99);
            hold = (r < 15) ? 0 : (r < 30) ? 1 : $urandom_range(2, 12);
            avg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            set_config($urandom_range(0, 3), tmo_ticks, hold, avg, int'($urandom));
            hang_pct = $urandom_range(2, 10);
            noise_pct = ($urandom_range(0, 9) < 3) ? $urandom_range(5, 20) : 0;
            src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            start_pct = $urandom_range(50, 100);
            repeat ($urandom_range(60, 200)) begin
                next_tick(start_pct);
                rand_ticks++;
            end
        end
        hang_pct = 0;
        noise_pct = 0;
        drain();
    endtask

    initial begin : sink_side
        int n;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                n = sink_hold;
                sink_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_beats
        t_tick_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tick_out_q.size() == 0) begin
                $error("output beat with no tick waiting for it");
                fail_count++;
            end else begin
                want = tick_out_q.pop_front();
                check_field("pd_sck_level", want.sck, m_axis_tdata[0]);
                check_field("busy_res", want.busy, m_axis_tdata[1]);
                check_field("result_value", $signed(want.value),
                            $signed(m_axis_tdata[RES_W+1:2]));
                check_field("result_valid", want.valid, m_axis_tuser[0]);
                check_field("timed_out", want.tmo, m_axis_tuser[1]);
            end
        end
    end

    initial begin : run_limit
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_after_reset();
        test_default_read();
        test_gain_pulses();
        test_result_range();
        test_ready_timeout();
        test_short_hold();
        test_averaging();
        test_config_mid_run();
        test_backpressure();
        test_limits();
        test_random_traffic();
        drain();
        repeat (NBITS + 16) @(posedge i_clk);
        if (tick_out_q.size() != 0) begin
            $error("%0d expected beats never arrived", tick_out_q.size());
            fail_count++;
        end
        $display("Checked %0d ticks: %0d finished measurements and %0d ready timeouts.",
                 n_ticks, n_results, n_timeouts);
        $display("Used %0d register writes, gain counts 0 to 3, averages of up to four reads.",
                 n_writes);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lcasr_pkg.sv
src/lcasr_div.sv
src/load_cell_adc_serial_reader.sv
bench/tb.sv
